FILE: rtl/core/gepi_pkg.sv
// Package for the GEMM epilogue requantizer: destination and register codes,
// and the fp32 multiply, add, pack and convert functions used by the pipeline.
// No dependencies.
package gepi_pkg;

    typedef enum logic [1:0] {
        DT_FP32 = 2'd0,
        DT_BF16 = 2'd1,
        DT_S8   = 2'd2,
        DT_U8   = 2'd3
    } dest_type_t;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DEST_TYPE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RCP_SCALE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT   = 3'd4;

    localparam logic [31:0] FP_ONE        = 32'h3F80_0000;
    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] S32_MIN_BITS  = 32'hCF00_0000;
    localparam logic [31:0] S32_INVALID   = 32'h8000_0000;

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    // Rounds s * m * 2^x to fp32, nearest even, with subnormals and overflow.
    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] x,
                                               input logic [49:0] m);
        logic [5:0] lz;
        logic [49:0] mn;
        logic signed [11:0] be;
        logic [5:0] sh;
        logic [99:0] tmp;
        logic st;
        logic up;
        logic [7:0] ef;
        logic [30:0] mag;
        lz = 6'd0;
        for (int i = 0; i < 50; i++)
        begin
            if (m[i])
            begin
                lz = 6'(49 - i);
            end
        end
        mn = m << lz;
        be = x + 12'sd176 - $signed({6'b0, lz});
        st = 1'b0;
        ef = 8'd0;
        if (be < 12'sd1)
        begin
            sh = (be < -12'sd48) ? 6'd50 : 6'(12'sd1 - be);
            tmp = {mn, 50'b0} >> sh;
            mn = tmp[99:50];
            st = |tmp[49:0];
        end
        else if (be >= 12'sd255)
        begin
            return {s, 8'hFF, 23'd0};
        end
        else
        begin
            ef = be[7:0];
        end
        up = mn[25] & (st | (|mn[24:0]) | mn[26]);
        mag = {ef, mn[48:26]} + 31'(up);
        return {s, mag};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        logic [8:0] ea;
        logic [8:0] eb;
        logic [47:0] p;
        logic signed [11:0] x;
        s = a[31] ^ b[31];
        ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
        eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
        p = {a[30:23] != 8'd0, a[22:0]} * {b[30:23] != 8'd0, b[22:0]};
        x = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 12'sd300;
        if (is_nan(a))
        begin
            return a | 32'h0040_0000;
        end
        else if (is_nan(b))
        begin
            return b | 32'h0040_0000;
        end
        else if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a)))
        begin
            return FP_DEFAULT_NAN;
        end
        else if (is_inf(a) || is_inf(b))
        begin
            return {s, 8'hFF, 23'd0};
        end
        else if (is_zero(a) || is_zero(b))
        begin
            return {s, 31'd0};
        end
        return round_pack(s, x, {2'b0, p});
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [8:0] eh;
        logic [8:0] el;
        logic [8:0] d;
        logic [5:0] dc;
        logic [49:0] ma;
        logic [49:0] mb;
        logic [99:0] tmp;
        logic [49:0] sum;
        if (a[30:0] >= b[30:0])
        begin
            hi = a;
            lo = b;
        end
        else
        begin
            hi = b;
            lo = a;
        end
        eh = (hi[30:23] == 8'd0) ? 9'd1 : {1'b0, hi[30:23]};
        el = (lo[30:23] == 8'd0) ? 9'd1 : {1'b0, lo[30:23]};
        d = eh - el;
        dc = (d > 9'd50) ? 6'd50 : d[5:0];
        ma = {1'b0, hi[30:23] != 8'd0, hi[22:0], 25'd0};
        mb = {1'b0, lo[30:23] != 8'd0, lo[22:0], 25'd0};
        tmp = {mb, 50'b0} >> dc;
        mb = tmp[99:50] | {49'd0, |tmp[49:0]};
        sum = (hi[31] == lo[31]) ? ma + mb : ma - mb;
        if (is_nan(a))
        begin
            return a | 32'h0040_0000;
        end
        else if (is_nan(b))
        begin
            return b | 32'h0040_0000;
        end
        else if (is_inf(a) && is_inf(b) && (a[31] != b[31]))
        begin
            return FP_DEFAULT_NAN;
        end
        else if (is_inf(hi))
        begin
            return hi;
        end
        else if (is_zero(a) && is_zero(b))
        begin
            return {a[31] & b[31], 31'd0};
        end
        else if (sum == 50'd0)
        begin
            return 32'd0;
        end
        return round_pack(hi[31], $signed({3'b0, eh}) - 12'sd175, sum);
    endfunction

    function automatic logic [31:0] byte_to_fp(input logic s, input logic [7:0] mag);
        if (mag == 8'd0)
        begin
            return 32'd0;
        end
        return round_pack(s, 12'sd0, {42'd0, mag});
    endfunction

    // Converts to a 32-bit integer, nearest even; NaN and out of range give -2^31.
    function automatic logic [31:0] fp_to_s32(input logic [31:0] x);
        logic [8:0] e;
        logic [23:0] m;
        logic [31:0] mag;
        logic [8:0] sh;
        logic [5:0] shc;
        logic [49:0] tmp;
        logic [23:0] ip;
        logic up;
        e = (x[30:23] == 8'd0) ? 9'd1 : {1'b0, x[30:23]};
        m = {x[30:23] != 8'd0, x[22:0]};
        if (is_nan(x) || ((x[30:23] >= 8'd158) && (x != S32_MIN_BITS)))
        begin
            return S32_INVALID;
        end
        if (e >= 9'd150)
        begin
            mag = {8'd0, m} << (e - 9'd150);
        end
        else
        begin
            sh = 9'd150 - e;
            shc = (sh > 9'd26) ? 6'd26 : sh[5:0];
            tmp = {m, 26'd0} >> shc;
            ip = tmp[49:26];
            up = tmp[25] & ((|tmp[24:0]) | ip[0]);
            mag = {8'd0, ip} + 32'(up);
        end
        return x[31] ? (32'd0 - mag) : mag;
    endfunction

    function automatic logic [15:0] fp_to_bf16(input logic [31:0] b);
        logic [31:0] t;
        t = b + 32'h0000_7FFF + {31'd0, b[16]};
        if (is_nan(b))
        begin
            return b[31:16] | 16'h0040;
        end
        return t[31:16];
    endfunction

endpackage

FILE: rtl/core/gepi_if.sv
// Channel interfaces of the GEMM epilogue requantizer: element requests,
// result requests and configuration writes. Depends on gepi_pkg.
interface gepi_item_if;
    logic        valid;
    logic        ready;
    logic [31:0] acc_value;
    logic        bias_present;
    logic [31:0] bias_value;
    logic [31:0] old_dest;

    modport source (output valid, acc_value, bias_present, bias_value, old_dest,
                    input ready);
    modport sink (input valid, acc_value, bias_present, bias_value, old_dest,
                  output ready);
endinterface

interface gepi_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;

    modport source (output valid, result_value, input ready);
    modport sink (input valid, result_value, output ready);
endinterface

interface gepi_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [gepi_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                 data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/gemm_epilogue_requantize.sv
// Top level of the GEMM epilogue requantizer: scale, bias, old-value blend
// and store conversion in a six-stage pipeline. Depends on gepi_pkg, gepi_if.
//
//  Channel   Role   Request carries
//  item      sink   acc_value, bias_present, bias_value, old_dest
//  result    source result_value
//  cfg       sink   index, data
//
// One element enters per cycle while no stage stalls; each request moves through
// stages 0 to 5 in order; the fp32 multiply and add units sit in stages 1 to 4.
// Reset clears the valid bits and loads the register defaults.
// A stage holds its request while the next stage is full and stalled, so input
// is taken as long as any stage ahead has room.
module gemm_epilogue_requantize (
    input  logic           clk,
    input  logic           rst_n,
    gepi_item_if.sink      item,
    gepi_result_if.source  result,
    gepi_cfg_if.sink       cfg
);
    import gepi_pkg::*;

    localparam int NSTAGE = 6;

    dest_type_t  dest_type_reg;
    logic [31:0] alpha_reg;
    logic [31:0] beta_reg;
    logic [31:0] rcp_scale_reg;
    logic [31:0] zero_point_reg;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] rdy;

    dest_type_t  typ_reg [NSTAGE];
    logic [31:0] acc0_reg;
    logic [31:0] old0_reg;
    logic        bp_reg [2];
    logic [31:0] bias_reg [2];
    logic [31:0] v_reg [1:4];
    logic [31:0] prod_reg [1:2];
    logic [31:0] scaled4_reg;
    logic [31:0] res_reg;

    logic [31:0] old_next;
    logic [31:0] v1_next;
    logic [31:0] v2_next;
    logic [31:0] v3_next;
    logic [31:0] res_next;
    logic [31:0] q_sum;
    logic signed [31:0] q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_type_reg  <= DT_FP32;
            alpha_reg      <= FP_ONE;
            beta_reg       <= 32'd0;
            rcp_scale_reg  <= FP_ONE;
            zero_point_reg <= 32'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DEST_TYPE:  dest_type_reg  <= dest_type_t'(cfg.data[1:0]);
                REG_ALPHA:      alpha_reg      <= cfg.data;
                REG_BETA:       beta_reg       <= cfg.data;
                REG_RCP_SCALE:  rcp_scale_reg  <= cfg.data;
                REG_ZERO_POINT: zero_point_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    always_comb
    begin
        rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || result.ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        valid_next = valid_reg;
        if (rdy[0])
        begin
            valid_next[0] = item.valid;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (rdy[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    assign item.ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        case (dest_type_reg)
            DT_FP32: old_next = item.old_dest;
            DT_BF16: old_next = {item.old_dest[15:0], 16'd0};
            DT_S8:   old_next = byte_to_fp(item.old_dest[7],
                                           item.old_dest[7] ? 8'd0 - item.old_dest[7:0]
                                                            : item.old_dest[7:0]);
            default: old_next = byte_to_fp(1'b0, item.old_dest[7:0]);
        endcase
        v1_next = (alpha_reg != FP_ONE) ? fp_mul(alpha_reg, acc0_reg) : acc0_reg;
        v2_next = bp_reg[1] ? fp_add(v_reg[1], bias_reg[1]) : v_reg[1];
        v3_next = (beta_reg[30:0] != 31'd0) ? fp_add(v_reg[2], prod_reg[2]) : v_reg[2];
        q_sum = fp_to_s32(scaled4_reg) + zero_point_reg;
        q = $signed(q_sum);
        case (typ_reg[4])
            DT_FP32: res_next = v_reg[4];
            DT_BF16: res_next = {16'd0, fp_to_bf16(v_reg[4])};
            DT_S8:
            begin
                if (q < -32'sd128)
                begin
                    res_next = 32'h0000_0080;
                end
                else if (q > 32'sd127)
                begin
                    res_next = 32'h0000_007F;
                end
                else
                begin
                    res_next = {24'd0, q_sum[7:0]};
                end
            end
            default:
            begin
                if (q < 32'sd0)
                begin
                    res_next = 32'd0;
                end
                else if (q > 32'sd255)
                begin
                    res_next = 32'h0000_00FF;
                end
                else
                begin
                    res_next = {24'd0, q_sum[7:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && item.valid)
        begin
            typ_reg[0]  <= dest_type_reg;
            acc0_reg    <= item.acc_value;
            bp_reg[0]   <= item.bias_present;
            bias_reg[0] <= item.bias_value;
            old0_reg    <= old_next;
        end
        if (rdy[1] && valid_reg[0])
        begin
            typ_reg[1]  <= typ_reg[0];
            v_reg[1]    <= v1_next;
            prod_reg[1] <= fp_mul(beta_reg, old0_reg);
            bp_reg[1]   <= bp_reg[0];
            bias_reg[1] <= bias_reg[0];
        end
        if (rdy[2] && valid_reg[1])
        begin
            typ_reg[2]  <= typ_reg[1];
            v_reg[2]    <= v2_next;
            prod_reg[2] <= prod_reg[1];
        end
        if (rdy[3] && valid_reg[2])
        begin
            typ_reg[3] <= typ_reg[2];
            v_reg[3]   <= v3_next;
        end
        if (rdy[4] && valid_reg[3])
        begin
            typ_reg[4]  <= typ_reg[3];
            v_reg[4]    <= v_reg[3];
            scaled4_reg <= fp_mul(v_reg[3], rcp_scale_reg);
        end
        if (rdy[5] && valid_reg[4])
        begin
            typ_reg[5] <= typ_reg[4];
            res_reg    <= res_next;
        end
    end

    assign result.valid        = valid_reg[NSTAGE-1];
    assign result.result_value = res_reg;

    a_byte_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (typ_reg[5] == DT_S8 || typ_reg[5] == DT_U8)
        |-> res_reg[31:8] == 24'd0)
        else $error("byte result has nonzero high bits");

    a_bf16_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && typ_reg[5] == DT_BF16 |-> res_reg[31:16] == 16'd0)
        else $error("bf16 result has nonzero high bits");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !result.ready |-> !item.ready)
        else $error("request taken while the pipeline is full and stalled");

endmodule
